>>> design/pwm_timebase_and_duty_setup_macros.svh
// Assertion macros shared by the PWM timebase block.
`ifndef PWM_TIMEBASE_AND_DUTY_SETUP_MACROS_SVH
`define PWM_TIMEBASE_AND_DUTY_SETUP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PTDS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptds assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PTDS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptds assertion failed");

`endif

>>> design/ptds_pkg.sv
// Types, constants and the prescaler table of the PWM timebase block.
package ptds_pkg;

  localparam int unsigned DIV_W     = 32;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned CH_W      = 4;
  localparam int unsigned RES_W     = 5;
  localparam int unsigned PRESC_W   = 3;
  localparam int unsigned NUM_CHANNELS_DEF = 9;

  localparam logic [RES_W-1:0]    RES_MAX      = 5'd16;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd637;
  localparam logic [PRESC_W-1:0]  PRESC_LAST   = 3'd7;
  localparam logic [DIV_W-1:0]    CLOCK_RESET  = 32'd80000000;
  localparam logic [DIV_W-1:0]    FREQ_RESET   = 32'd490;
  localparam logic [RES_W-1:0]    RES_RESET    = 5'd8;

  // The clock dividers 1, 2, 4, 6, 16, 32, 64 and 256 are right shifts; the divider
  // of six also needs a divide by three after its shift.
  localparam logic [3:0] PRESC_SHIFT [8] = '{
    4'd0, 4'd1, 4'd2, 4'd1, 4'd4, 4'd5, 4'd6, 4'd8
  };
  localparam logic [PRESC_W-1:0] PRESC_DIV3 = 3'd3;

  // (2^33 + 1) / 3: multiplying by it and shifting right by 33 divides any 32-bit
  // value by three exactly.
  localparam logic [DIV_W-1:0] THIRD_RECIP = 32'hAAAA_AAAB;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_OFF   = 1'b1
  } ptds_op_t;

  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_PWM  = 2'd2,
    MODE_OFF  = 2'd3
  } ptds_mode_t;

  typedef enum logic [1:0] {
    REG_CLOCK_HZ   = 2'd0,
    REG_PWM_FREQ   = 2'd1,
    REG_RESOLUTION = 2'd2
  } ptds_reg_t;

  typedef struct packed {
    ptds_op_t            opcode;
    logic [CH_W-1:0]     channel;
    logic                pwm_capable;
    logic [VALUE_W-1:0]  value;
  } ptds_in_t;

  typedef struct packed {
    ptds_mode_t          mode;
    logic [PERIOD_W-1:0] duty_compare;
    logic [PERIOD_W-1:0] timer_period;
    logic [PRESC_W-1:0]  prescaler_code;
    logic                timer_enabled;
    logic                channel_was_new;
  } ptds_out_t;

  typedef struct packed {
    logic [1:0]       index;
    logic [DIV_W-1:0] value;
  } ptds_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_load;
    logic eval_apply;
    logic code_clear;
    logic code_inc;
    logic div_start;
    logic tb_store;
    logic tb_saturate;
    logic mul;
    logic shift;
    logic out_load;
  } ptds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pwm;
    logic mask_empty;
    logic div_busy;
    logic fits;
    logic code_last;
  } ptds_sts_t;

endpackage

>>> design/ptds_chan_if.sv
// Valid/ready channel interface carrying one payload type.
interface ptds_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/ptds_div.sv
// Restoring unsigned divider producing one quotient bit per cycle.
module ptds_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ptds_pkg::DIV_W-1:0] dividend,
  input  logic [ptds_pkg::DIV_W-1:0] divisor,
  output logic                      busy,
  output logic [ptds_pkg::DIV_W-1:0] quotient
);
  import ptds_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_W:0]   trial;

  // The remainder stays below the divisor, so the top bit of the trial is the borrow.
  assign trial = {rem_r, quo_r[DIV_W-1]} - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
      if (!trial[DIV_W]) begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> design/ptds_dp.sv
// Datapath: configuration, channel mask, timebase search and duty computation.
module ptds_dp #(
  parameter int unsigned NUM_CHANNELS = ptds_pkg::NUM_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  ptds_pkg::ptds_cfg_t cfg_data,
  input  ptds_pkg::ptds_in_t  in_data,
  input  ptds_pkg::ptds_cmd_t cmd,
  output ptds_pkg::ptds_sts_t sts,
  output ptds_pkg::ptds_out_t out_data
);
  import ptds_pkg::*;

  logic [DIV_W-1:0]        clock_r;
  logic [DIV_W-1:0]        freq_r;
  logic [RES_W-1:0]        res_r;
  logic [NUM_CHANNELS-1:0] mask_r;
  logic [PERIOD_W-1:0]     period_r;
  logic [PRESC_W-1:0]      presc_r;
  logic [PRESC_W-1:0]      code_r;
  ptds_in_t                item_r;
  ptds_mode_t              mode_r;
  logic [PERIOD_W-1:0]     duty_r;
  logic                    was_new_r;
  logic [2*PERIOD_W-1:0]   product_r;
  ptds_out_t               out_r;

  logic [NUM_CHANNELS-1:0] ch_bit;
  logic                    in_range;
  logic [RES_W-1:0]        res_eff;
  logic [RES_MAX:0]        full;
  logic [RES_MAX:0]        full_m1;
  logic [RES_MAX:0]        half;
  logic [RES_MAX:0]        value_x;
  logic                    steady;
  logic                    level_high;
  logic [DIV_W-1:0]        freq_eff;
  logic [DIV_W-1:0]        clk_shifted;
  logic [2*DIV_W-1:0]      third_prod;
  logic [DIV_W-1:0]        div_dividend;
  logic [DIV_W-1:0]        div_divisor;
  logic                    div_busy;
  logic [DIV_W-1:0]        quotient;
  logic [2*PERIOD_W-1:0]   shifted;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch_bit[i] = (item_r.channel == CH_W'(i));
    end
  end
  assign in_range = |ch_bit;

  // Resolution above sixteen acts as sixteen.
  assign res_eff    = (res_r > RES_MAX) ? RES_MAX : res_r;
  assign full       = (RES_MAX + 1)'(1) << res_eff;
  assign full_m1    = full - (RES_MAX + 1)'(1);
  assign half       = full >> 1;
  assign value_x    = (RES_MAX + 1)'(item_r.value);
  assign steady     = !item_r.pwm_capable || !in_range || (item_r.value == '0) ||
                      (value_x >= full_m1);
  assign level_high = (value_x >= half);

  assign freq_eff = (freq_r == '0) ? DIV_W'(1) : freq_r;

  // The prescaled clock needs no divider: a shift, plus a multiply by the
  // reciprocal of three for the divider of six.
  assign clk_shifted  = clock_r >> PRESC_SHIFT[code_r];
  assign third_prod   = clk_shifted * THIRD_RECIP;
  assign div_dividend = (code_r == PRESC_DIV3) ? {1'b0, third_prod[2*DIV_W-1:DIV_W+1]} :
                        clk_shifted;
  assign div_divisor  = freq_eff;

  ptds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign shifted = product_r >> res_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r  <= CLOCK_RESET;
      freq_r   <= FREQ_RESET;
      res_r    <= RES_RESET;
      mask_r   <= '0;
      period_r <= PERIOD_RESET;
      presc_r  <= '0;
      code_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_data.index)
          REG_CLOCK_HZ:   clock_r <= cfg_data.value;
          REG_PWM_FREQ:   freq_r  <= cfg_data.value;
          REG_RESOLUTION: res_r   <= cfg_data.value[RES_W-1:0];
          default: ;
        endcase
      end
      if (cmd.code_clear) begin
        code_r <= '0;
      end else if (cmd.code_inc) begin
        code_r <= code_r + PRESC_W'(1);
      end
      if (cmd.tb_store) begin
        period_r <= quotient[PERIOD_W-1:0];
        presc_r  <= code_r;
      end else if (cmd.tb_saturate) begin
        period_r <= PERIOD_MAX;
        presc_r  <= PRESC_LAST;
      end
      if (cmd.eval_apply) begin
        // A turn-off always clears; a steady write clears only for a capable pin.
        if (item_r.opcode == OP_OFF || item_r.pwm_capable) begin
          mask_r <= mask_r & ~ch_bit;
        end
      end else if (cmd.mul) begin
        mask_r <= mask_r | ch_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_r <= in_data;
    end
    if (cmd.eval_apply) begin
      duty_r    <= '0;
      was_new_r <= 1'b0;
      if (item_r.opcode == OP_OFF) begin
        mode_r <= MODE_OFF;
      end else begin
        mode_r <= level_high ? MODE_HIGH : MODE_LOW;
      end
    end
    if (cmd.mul) begin
      product_r <= period_r * item_r.value;
      was_new_r <= ((mask_r & ch_bit) == '0);
      mode_r    <= MODE_PWM;
    end
    if (cmd.shift) begin
      duty_r <= shifted[PERIOD_W-1:0];
    end
    if (cmd.out_load) begin
      out_r.mode            <= mode_r;
      out_r.duty_compare    <= duty_r;
      out_r.timer_period    <= period_r;
      out_r.prescaler_code  <= presc_r;
      out_r.timer_enabled   <= (mask_r != '0);
      out_r.channel_was_new <= was_new_r;
    end
  end

  assign sts.is_pwm     = (item_r.opcode == OP_WRITE) && !steady;
  assign sts.mask_empty = (mask_r == '0);
  assign sts.div_busy   = div_busy;
  assign sts.fits       = (quotient[DIV_W-1:PERIOD_W] == '0);
  assign sts.code_last  = (code_r == PRESC_LAST);

  assign out_data = out_r;

endmodule

>>> design/ptds_ctrl.sv
// Controller state machine sequencing each request through the datapath.
`include "pwm_timebase_and_duty_setup_macros.svh"

module ptds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  input  ptds_pkg::ptds_sts_t sts,
  output logic                in_ready,
  output logic                out_valid,
  output ptds_pkg::ptds_cmd_t cmd
);
  import ptds_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_EVAL  = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_DIV_W = 8'b00001000,
    S_CHECK = 8'b00010000,
    S_MUL   = 8'b00100000,
    S_SHIFT = 8'b01000000,
    S_DONE  = 8'b10000000
  } ptds_state_t;

  ptds_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts.is_pwm) begin
          cmd.eval_apply = 1'b1;
          state_nxt      = S_DONE;
        end else if (sts.mask_empty) begin
          // First active channel: search the dividers for a period that fits.
          cmd.code_clear = 1'b1;
          state_nxt      = S_DIV;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_W;
      end
      S_DIV_W: begin
        if (!sts.div_busy) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.fits) begin
          cmd.tb_store = 1'b1;
          state_nxt    = S_MUL;
        end else if (sts.code_last) begin
          cmd.tb_saturate = 1'b1;
          state_nxt       = S_MUL;
        end else begin
          cmd.code_inc = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PTDS_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  `PTDS_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `PTDS_ASSERT_IMP(a_div_start_idle, clk, rst_n, cmd.div_start, !sts.div_busy)
  `PTDS_ASSERT_IMP(a_code_in_range, clk, rst_n, cmd.code_inc, !sts.code_last)

endmodule

>>> design/pwm_timebase_and_duty_setup.sv
// Top level of the PWM timebase and duty setup block.
//
//   channel  direction  payload                                     handshake
//   in_ch    sink       opcode, channel, pwm_capable, value         valid/ready
//   out_ch   source     mode, duty, period, prescaler, flags        valid/ready
//   cfg_ch   sink       register index, 32-bit write data           valid/ready
//
// A steady level or a turn-off passes EVAL and DONE; a PWM write on a running timebase
// passes EVAL, MUL, SHIFT and DONE. The first activating write searches the dividers:
// each divider tried runs one 32-step division by the frequency (DIV, DIV_W, CHECK),
// and the chosen or saturated timebase then goes on through MUL, SHIFT and DONE.
// One request is in flight at a time; a new one is taken while the last result waits.
// Reset is synchronous and active low; configuration writes are always accepted.
module pwm_timebase_and_duty_setup #(
  parameter int unsigned NUM_CHANNELS = ptds_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ptds_chan_if.sink   in_ch,
  ptds_chan_if.source out_ch,
  ptds_chan_if.sink   cfg_ch
);
  import ptds_pkg::*;

  ptds_cmd_t cmd;
  ptds_sts_t sts;
  ptds_in_t  in_data;
  ptds_out_t out_data;
  ptds_cfg_t cfg_data;
  logic      in_ready;
  logic      out_valid;

  assign in_data  = in_ch.data;
  assign cfg_data = cfg_ch.data;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  ptds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ptds_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the PWM timebase and duty setup block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptds_pkg::*;

  localparam int unsigned NCH         = NUM_CHANNELS_DEF;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned PRINT_LIMIT = 40;
  localparam int unsigned RAND_PER_PHASE = 85;
  localparam int unsigned NUM_PHASES  = 12;
  localparam logic [31:0] CLOCK_DIVS [8] = '{
    32'd1, 32'd2, 32'd4, 32'd6, 32'd16, 32'd32, 32'd64, 32'd256
  };

  logic clk = 1'b0;
  logic rst_n;

  ptds_chan_if #(.payload_t(ptds_in_t))  in_ch ();
  ptds_chan_if #(.payload_t(ptds_out_t)) out_ch ();
  ptds_chan_if #(.payload_t(ptds_cfg_t)) cfg_ch ();

  pwm_timebase_and_duty_setup dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Predicted block state and configuration.
  logic [31:0]    clock_hz_cfg;
  logic [31:0]    freq_hz_cfg;
  logic [4:0]     res_bits_cfg;
  logic [NCH-1:0] active_chans;
  logic [15:0]    period_now;
  logic [2:0]     presc_now;

  ptds_in_t  outgoing_requests [$];
  ptds_out_t due_status [$];
  int unsigned reqs_issued = 0;
  int unsigned reqs_taken  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic in_fire  = 1'b0;
  logic cfg_fire = 1'b0;
  logic steady_flow = 1'b0;

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // First divider whose period fits in 16 bits wins; otherwise saturate.
  function automatic void pick_timebase();
    logic [31:0] freq;
    logic [31:0] cand;
    logic        found;
    int          code;
    freq = (freq_hz_cfg == 32'd0) ? 32'd1 : freq_hz_cfg;
    found = 1'b0;
    period_now = PERIOD_MAX;
    presc_now = PRESC_LAST;
    for (code = 0; code < 8; code++) begin
      cand = (clock_hz_cfg / CLOCK_DIVS[code]) / freq;
      if (!found && cand <= 32'h0000_FFFF) begin
        period_now = cand[15:0];
        presc_now = code[2:0];
        found = 1'b1;
      end
    end
  endfunction

  function automatic ptds_out_t apply_pwm_request(ptds_in_t req);
    ptds_out_t      res;
    logic [4:0]     eff_res;
    logic [16:0]    full;
    logic           in_range;
    logic [NCH-1:0] ch_bit;
    logic [31:0]    product;
    res = '0;
    in_range = (req.channel < NCH);
    ch_bit = in_range ? (NCH'(1) << req.channel) : '0;
    eff_res = (res_bits_cfg > RES_MAX) ? RES_MAX : res_bits_cfg;
    full = 17'd1 << eff_res;
    if (req.opcode == OP_OFF) begin
      active_chans &= ~ch_bit;
      res.mode = MODE_OFF;
    end else if (!req.pwm_capable || !in_range || req.value == '0 ||
                 {1'b0, req.value} >= full - 17'd1) begin
      res.mode = ({1'b0, req.value} < (full >> 1)) ? MODE_LOW : MODE_HIGH;
      if (req.pwm_capable) active_chans &= ~ch_bit;
    end else begin
      if (active_chans == '0) pick_timebase();
      if ((active_chans & ch_bit) == '0) begin
        res.channel_was_new = 1'b1;
        active_chans |= ch_bit;
      end
      product = 32'(period_now) * 32'(req.value);
      res.duty_compare = 16'(product >> eff_res);
      res.mode = MODE_PWM;
    end
    res.timer_period = period_now;
    res.prescaler_code = presc_now;
    res.timer_enabled = (active_chans != '0);
    return res;
  endfunction

  function automatic void store_setting(ptds_cfg_t w);
    case (w.index)
      REG_CLOCK_HZ:   clock_hz_cfg = w.value;
      REG_PWM_FREQ:   freq_hz_cfg = w.value;
      REG_RESOLUTION: res_bits_cfg = w.value[4:0];
      default: ;
    endcase
  endfunction

  task automatic check_status(ptds_out_t got);
    ptds_out_t want;
    if (due_status.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with no request pending", got));
    end else begin
      want = due_status.pop_front();
      if (got.mode != want.mode)
        report_mismatch($sformatf("mode %0d, predicted %0d", got.mode, want.mode));
      if (got.duty_compare != want.duty_compare)
        report_mismatch($sformatf("duty %0d, predicted %0d",
                                  got.duty_compare, want.duty_compare));
      if (got.timer_period != want.timer_period)
        report_mismatch($sformatf("period %0d, predicted %0d",
                                  got.timer_period, want.timer_period));
      if (got.prescaler_code != want.prescaler_code)
        report_mismatch($sformatf("prescaler %0d, predicted %0d",
                                  got.prescaler_code, want.prescaler_code));
      if (got.timer_enabled != want.timer_enabled)
        report_mismatch($sformatf("timer enable %0b, predicted %0b",
                                  got.timer_enabled, want.timer_enabled));
      if (got.channel_was_new != want.channel_was_new)
        report_mismatch($sformatf("new channel flag %0b, predicted %0b",
                                  got.channel_was_new, want.channel_was_new));
    end
  endtask

  // Monitor: all handshakes are observed here, at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    in_fire <= in_ch.valid && in_ch.ready;
    cfg_fire <= cfg_ch.valid && cfg_ch.ready;
    if (!rst_n) begin
      clock_hz_cfg = CLOCK_RESET;
      freq_hz_cfg = FREQ_RESET;
      res_bits_cfg = RES_RESET;
      active_chans = '0;
      period_now = PERIOD_RESET;
      presc_now = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) store_setting(cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        due_status.push_back(apply_pwm_request(in_ch.data));
        reqs_taken++;
      end
      if (out_ch.valid && out_ch.ready) check_status(out_ch.data);
    end
  end

  // Request driver.
  int unsigned in_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (outgoing_requests.size() > 0) begin
        in_ch.data <= outgoing_requests.pop_front();
        in_ch.valid <= 1'b1;
        in_gap = idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure.
  int unsigned out_hold = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_hold = idle_len();
    end
  end

  task automatic queue_request(ptds_op_t op, int unsigned ch, bit cap, int unsigned val);
    ptds_in_t req;
    req.opcode = op;
    req.channel = 4'(ch);
    req.pwm_capable = cap;
    req.value = 16'(val);
    outgoing_requests.push_back(req);
    reqs_issued++;
  endtask

  // Values cluster around zero, full scale and half scale.
  task automatic queue_random_request(int unsigned full);
    ptds_op_t    op;
    int unsigned ch;
    int unsigned val;
    op = ($urandom_range(0, 3) == 0) ? OP_OFF : OP_WRITE;
    ch = ($urandom_range(0, 9) == 0) ? $urandom_range(NCH, 15) : $urandom_range(0, NCH - 1);
    case ($urandom_range(0, 11))
      0:       val = 0;
      1:       val = 1;
      2:       val = full - 1;
      3:       val = full - 2;
      4:       val = full / 2;
      5:       val = full / 2 - 1;
      6:       val = full;
      7:       val = $urandom;
      default: val = $urandom_range(1, (full > 3) ? full - 2 : 1);
    endcase
    queue_request(op, ch, ($urandom_range(0, 9) != 0), val);
  endtask

  // Returns at a falling edge once every request has its result.
  task automatic wait_idle();
    @(negedge clk);
    while (reqs_taken != reqs_issued || due_status.size() != 0) @(negedge clk);
  endtask

  task automatic write_settings(logic [31:0] clk_hz, logic [31:0] freq_hz, logic [4:0] res);
    cfg_ch.data <= '{index: REG_CLOCK_HZ, value: clk_hz};
    cfg_ch.valid <= 1'b1;
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.data <= '{index: REG_PWM_FREQ, value: freq_hz};
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.data <= '{index: REG_RESOLUTION, value: 32'(res)};
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] clk_set;
    logic [31:0] freq_set;
    logic [4:0]  res_set;
    int unsigned full;
    int unsigned phase;
    int unsigned n;

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset configuration, full scale 256.
    queue_request(OP_WRITE, 2, 1, 255);     // steady high, shows reset period
    queue_request(OP_WRITE, 0, 1, 128);     // first PWM, timebase search
    queue_request(OP_WRITE, 0, 1, 200);     // already active
    queue_request(OP_WRITE, 1, 1, 1);
    queue_request(OP_WRITE, 1, 1, 254);
    queue_request(OP_WRITE, 1, 1, 0);       // steady low clears the channel
    queue_request(OP_WRITE, 3, 0, 128);     // pin without compare unit
    queue_request(OP_WRITE, 8, 1, 100);
    queue_request(OP_WRITE, 9, 1, 100);     // channel out of range
    queue_request(OP_WRITE, 15, 1, 65535);
    queue_request(OP_OFF, 15, 1, 0);
    queue_request(OP_OFF, 5, 1, 0);         // turn-off of an inactive channel
    queue_request(OP_OFF, 8, 1, 0);
    queue_request(OP_OFF, 0, 1, 65535);     // mask empties, timer stops
    queue_request(OP_WRITE, 4, 0, 65535);
    queue_request(OP_OFF, 0, 0, 65535);
    queue_request(OP_WRITE, 7, 1, 127);
    queue_request(OP_WRITE, 7, 1, 128);
    queue_request(OP_WRITE, 6, 1, 65534);
    wait_idle();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin clk_set = 32'd80_000_000; freq_set = 32'd490; res_set = 5'd8; end
        1: begin clk_set = 32'hFFFF_FFFF; freq_set = 32'd1; res_set = 5'd16; end
        2: begin clk_set = 32'd1; freq_set = 32'hFFFF_FFFF; res_set = 5'd0; end
        3: begin clk_set = 32'd48_000_000; freq_set = 32'd0; res_set = 5'd12; end
        4: begin clk_set = 32'hFFFF_FFFF; freq_set = 32'hFFFF_FFFF; res_set = 5'd31; end
        5: begin clk_set = 32'd0; freq_set = 32'd1000; res_set = 5'd17; end
        default: begin
          clk_set = $urandom;
          case ($urandom_range(0, 2))
            0:       freq_set = $urandom_range(1, 2000);
            1:       freq_set = $urandom_range(1, 200_000);
            default: freq_set = $urandom;
          endcase
          res_set = 5'($urandom_range(0, 31));
        end
      endcase
      full = 1 << ((res_set > 16) ? 16 : res_set);
      steady_flow = (phase % 4 == 3);
      write_settings(clk_set, freq_set, res_set);

      // Clear every channel so the new settings drive a fresh timebase search.
      for (n = 0; n < NCH; n++) queue_request(OP_OFF, n, 1, 0);
      for (n = 0; n < RAND_PER_PHASE; n++) queue_random_request(full);
      wait_idle();
    end

    repeat (50) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
